@@ src/psd_pkg.sv @@
// shared types, constants and lookup functions for the register stream decompressor
package psd_pkg;

  localparam int unsigned FRAG_ROWS = 128;
  localparam int unsigned NUM_REGS  = 14;
  localparam int unsigned HALF_BITS = 7;
  localparam int unsigned WIN_ROWS  = 2 * FRAG_ROWS;
  localparam int unsigned WIN_DEPTH = NUM_REGS * WIN_ROWS;

  localparam int unsigned ROW_W    = $clog2(FRAG_ROWS);
  localparam int unsigned SLOT_W   = $clog2(WIN_ROWS);
  localparam int unsigned REG_W    = 4;
  localparam int unsigned FRAG_W   = 10;
  localparam int unsigned ROWABS_W = FRAG_W + ROW_W;
  localparam int unsigned ADDR_W   = $clog2(WIN_DEPTH);

  localparam logic [2:0] ST_TAKEN    = 3'd0;
  localparam logic [2:0] ST_REFUSED  = 3'd1;
  localparam logic [2:0] ST_VALUE    = 3'd2;
  localparam logic [2:0] ST_STARVED  = 3'd3;
  localparam logic [2:0] ST_FINISHED = 3'd4;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] byte_in;
  } psd_in_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [REG_W-1:0]    reg_index;
    logic [ROWABS_W-1:0] row_index;
    logic [7:0]          reg_value;
    logic                padding;
  } psd_out_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic rd_phase;
    logic clear;
  } psd_cmd_t;

  typedef struct packed {
    logic done;
    logic need_read;
    logic clear_last;
  } psd_sts_t;

  function automatic logic [3:0] reg_width(input logic [REG_W-1:0] idx);
    logic [3:0] w;
    case (idx)
      4'd0:    w = 4'd8;
      4'd1:    w = 4'd4;
      4'd2:    w = 4'd8;
      4'd3:    w = 4'd4;
      4'd4:    w = 4'd8;
      4'd5:    w = 4'd4;
      4'd6:    w = 4'd5;
      4'd7:    w = 4'd8;
      4'd8:    w = 4'd5;
      4'd9:    w = 4'd5;
      4'd10:   w = 4'd5;
      4'd11:   w = 4'd8;
      4'd12:   w = 4'd8;
      4'd13:   w = 4'd8;
      default: w = 4'd8;
    endcase
    return w;
  endfunction

endpackage

@@ src/psg_register_stream_decompressor.sv @@
// top level of the register stream decompressor
// timing: a load, or a fetch that ends at once, is captured in the item register on acceptance and
//   its result is then registered by the decode step; a fetch is parsed serially, consuming at most
//   8 stream bits plus one window read for a copy; decode steps wait while a stalled result is held
// throughput: one transaction at a time, the next accepted the cycle after the result registers
// reset: clearing pass over all 3584 history window entries with intake stalled
module psg_register_stream_decompressor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  psd_pkg::psd_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output psd_pkg::psd_out_t  out_data_o
);

  psd_pkg::psd_cmd_t cmd;
  psd_pkg::psd_sts_t sts;

  psd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  psd_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

@@ src/psd_ctrl.sv @@
// sequencing state machine: clearing pass, transaction intake, decode steps, output register valid
module psd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output psd_pkg::psd_cmd_t   cmd_o,
  input  psd_pkg::psd_sts_t   sts_i
);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_DECODE = 2'd2;
  localparam logic [1:0] S_RDWAIT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       busy;

  assign out_free = !out_valid_q || !out_stall_i;
  assign busy     = (state_q == S_DECODE) || (state_q == S_RDWAIT);

  assign cmd_o.accept   = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.step     = busy && out_free;
  assign cmd_o.rd_phase = (state_q == S_RDWAIT);
  assign cmd_o.clear    = (state_q == S_CLEAR);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (cmd_o.step) begin
          if (sts_i.done) state_d = S_IDLE;
          else if (sts_i.need_read) state_d = S_RDWAIT;
        end
      end
      S_RDWAIT: begin
        if (cmd_o.step) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.step && sts_i.done) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ src/psd_dp.sv @@
// datapath: bit buffer, header, parser registers, current values, history window and result register
module psd_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psd_pkg::psd_in_t    in_data_i,
  input  psd_pkg::psd_cmd_t   cmd_i,
  output psd_pkg::psd_sts_t   sts_o,
  output psd_pkg::psd_out_t   out_data_o
);

  localparam logic [2:0] PS_FRAG_FLAG = 3'd0;
  localparam logic [2:0] PS_ROW_FLAG  = 3'd1;
  localparam logic [2:0] PS_KIND      = 3'd2;
  localparam logic [2:0] PS_RAW       = 3'd3;
  localparam logic [2:0] PS_OFFSET    = 3'd4;
  localparam logic [2:0] PS_LENGTH    = 3'd5;
  localparam logic [2:0] PS_FILL      = 3'd6;
  localparam logic [2:0] PS_COPY      = 3'd7;

  localparam logic [1:0] HDR_LOW  = 2'd0;
  localparam logic [1:0] HDR_HIGH = 2'd1;
  localparam logic [1:0] HDR_DONE = 2'd2;

  localparam int unsigned RW  = psd_pkg::ROW_W;
  localparam int unsigned SW  = psd_pkg::SLOT_W;
  localparam int unsigned GW  = psd_pkg::REG_W;
  localparam int unsigned FW  = psd_pkg::FRAG_W;
  localparam int unsigned AW  = psd_pkg::ADDR_W;
  localparam int unsigned XW  = psd_pkg::ROWABS_W;

  psd_pkg::psd_in_t  item_q;
  psd_pkg::psd_out_t out_q, res;

  logic [7:0]    buf_q, buf_d;
  logic [3:0]    bits_q, bits_d;
  logic [1:0]    hdr_q, hdr_d;
  logic [15:0]   total_q, total_d;
  logic [FW-1:0] frag_q, frag_d;
  logic [GW-1:0] reg_q, reg_d;
  logic [RW-1:0] row_q, row_d;
  logic [2:0]    ps_q, ps_d;
  logic [7:0]    acc_q, acc_d;
  logic [3:0]    need_q, need_d;
  logic [SW-1:0] src_q, src_d;
  logic [7:0]    rem_q, rem_d;
  logic [7:0]    last_q [psd_pkg::NUM_REGS];
  logic [AW-1:0] clr_cnt_q;
  logic [7:0]    win_mem [psd_pkg::WIN_DEPTH];
  logic [7:0]    rd_q;

  logic          bit_w;
  logic [7:0]    acc_n;
  logic [3:0]    need_n;
  logic [SW-1:0] slot;
  logic [XW-1:0] row_abs;
  logic          finished;
  logic [8:0]    len;
  logic [8:0]    room;
  logic [7:0]    last_cur;
  logic [7:0]    rem_dec;
  logic          dlv;
  logic [7:0]    dlv_val;
  logic          done;
  logic          need_read;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;

  assign bit_w    = buf_q[7];
  assign acc_n    = {acc_q[6:0], bit_w};
  assign need_n   = (need_q != 4'd0) ? need_q - 4'd1 : 4'd0;
  assign slot     = {frag_q[0], row_q};
  assign row_abs  = {frag_q, row_q};
  assign finished = {frag_q, RW'(0)} >= XW'(total_q);
  assign len      = {1'b0, acc_n} + 9'd1;
  assign room     = 9'(psd_pkg::FRAG_ROWS) - 9'(row_q);
  assign last_cur = last_q[reg_q];
  assign rem_dec  = (rem_q != 8'd0) ? rem_q - 8'd1 : 8'd0;

  always_comb begin
    buf_d     = buf_q;
    bits_d    = bits_q;
    hdr_d     = hdr_q;
    total_d   = total_q;
    frag_d    = frag_q;
    reg_d     = reg_q;
    row_d     = row_q;
    ps_d      = ps_q;
    acc_d     = acc_q;
    need_d    = need_q;
    src_d     = src_q;
    rem_d     = rem_q;
    dlv       = 1'b0;
    dlv_val   = 8'd0;
    done      = 1'b0;
    need_read = 1'b0;
    res       = '0;

    if (item_q.mode == psd_pkg::MODE_LOAD) begin
      done = 1'b1;
      res.status = psd_pkg::ST_TAKEN;
      case (hdr_q)
        HDR_LOW: begin
          total_d = {8'd0, item_q.byte_in};
          hdr_d   = HDR_HIGH;
        end
        HDR_HIGH: begin
          total_d = {item_q.byte_in, total_q[7:0]};
          hdr_d   = HDR_DONE;
        end
        default: begin
          if (bits_q == 4'd0) begin
            buf_d  = item_q.byte_in;
            bits_d = 4'd8;
          end else begin
            res.status = psd_pkg::ST_REFUSED;
          end
        end
      endcase
    end else if (hdr_q != HDR_DONE) begin
      done = 1'b1;
      res.status = psd_pkg::ST_STARVED;
    end else if (finished) begin
      done = 1'b1;
      res.status = psd_pkg::ST_FINISHED;
    end else if (ps_q == PS_FILL) begin
      dlv     = 1'b1;
      dlv_val = last_cur;
    end else if (ps_q == PS_COPY) begin
      if (cmd_i.rd_phase) begin
        dlv     = 1'b1;
        dlv_val = rd_q;
      end else begin
        need_read = 1'b1;
      end
    end else if (bits_q == 4'd0) begin
      done = 1'b1;
      res.status = psd_pkg::ST_STARVED;
    end else begin
      buf_d  = {buf_q[6:0], 1'b0};
      bits_d = bits_q - 4'd1;
      case (ps_q)
        PS_FRAG_FLAG: begin
          ps_d = bit_w ? PS_ROW_FLAG : PS_FILL;
        end
        PS_ROW_FLAG: begin
          if (!bit_w) begin
            dlv     = 1'b1;
            dlv_val = last_cur;
          end else begin
            ps_d = PS_KIND;
          end
        end
        PS_KIND: begin
          acc_d = 8'd0;
          if (bit_w) begin
            ps_d   = PS_RAW;
            need_d = psd_pkg::reg_width(reg_q);
          end else begin
            ps_d   = PS_OFFSET;
            need_d = 4'(psd_pkg::HALF_BITS);
          end
        end
        default: begin
          acc_d  = acc_n;
          need_d = need_n;
          if (need_n == 4'd0) begin
            case (ps_q)
              PS_RAW: begin
                dlv     = 1'b1;
                dlv_val = acc_n;
              end
              PS_OFFSET: begin
                src_d  = slot + acc_n + SW'(psd_pkg::FRAG_ROWS);
                acc_d  = 8'd0;
                need_d = 4'(psd_pkg::HALF_BITS);
                ps_d   = PS_LENGTH;
              end
              default: begin
                rem_d = (len > room) ? room[7:0] : len[7:0];
                ps_d  = PS_COPY;
              end
            endcase
          end
        end
      endcase
    end

    if (dlv) begin
      done          = 1'b1;
      res.status    = psd_pkg::ST_VALUE;
      res.reg_index = reg_q;
      res.row_index = row_abs;
      res.reg_value = dlv_val;
      res.padding   = row_abs >= XW'(total_q);
      if (ps_q == PS_COPY) begin
        src_d = src_q + SW'(1);
        rem_d = rem_dec;
        ps_d  = (rem_dec == 8'd0) ? PS_ROW_FLAG : PS_COPY;
      end else if (ps_q != PS_FILL) begin
        ps_d = PS_ROW_FLAG;
      end
      if (row_q == RW'(psd_pkg::FRAG_ROWS - 1)) begin
        row_d = '0;
        ps_d  = PS_FRAG_FLAG;
        if (reg_q == GW'(psd_pkg::NUM_REGS - 1)) begin
          reg_d  = '0;
          frag_d = frag_q + FW'(1);
        end else begin
          reg_d = reg_q + GW'(1);
        end
      end else begin
        row_d = row_q + RW'(1);
      end
    end
  end

  assign sts_o.done       = done;
  assign sts_o.need_read  = need_read;
  assign sts_o.clear_last = (clr_cnt_q == AW'(psd_pkg::WIN_DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q     <= '0;
      bits_q    <= '0;
      hdr_q     <= HDR_LOW;
      total_q   <= '0;
      frag_q    <= '0;
      reg_q     <= '0;
      row_q     <= '0;
      ps_q      <= PS_FRAG_FLAG;
      acc_q     <= '0;
      need_q    <= '0;
      src_q     <= '0;
      rem_q     <= '0;
      clr_cnt_q <= '0;
      for (int i = 0; i < psd_pkg::NUM_REGS; i++) begin
        last_q[i] <= '0;
      end
    end else begin
      if (cmd_i.clear) clr_cnt_q <= clr_cnt_q + AW'(1);
      if (cmd_i.step) begin
        buf_q   <= buf_d;
        bits_q  <= bits_d;
        hdr_q   <= hdr_d;
        total_q <= total_d;
        frag_q  <= frag_d;
        reg_q   <= reg_d;
        row_q   <= row_d;
        ps_q    <= ps_d;
        acc_q   <= acc_d;
        need_q  <= need_d;
        src_q   <= src_d;
        rem_q   <= rem_d;
        if (dlv) last_q[reg_q] <= dlv_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) item_q <= in_data_i;
    if (cmd_i.step && done) out_q <= res;
  end

  // history window, one write and one registered read port
  assign we    = cmd_i.clear || (cmd_i.step && dlv);
  assign waddr = cmd_i.clear ? clr_cnt_q : {reg_q, slot};
  assign wdata = cmd_i.clear ? 8'd0 : dlv_val;
  assign raddr = {reg_q, src_q};

  always_ff @(posedge clk_i) begin
    if (we) win_mem[waddr] <= wdata;
    rd_q <= win_mem[raddr];
  end

  assign out_data_o = out_q;

endmodule

@@ src/psd_chk.sv @@
// port-level checker for the register stream decompressor, bound to the top level
module psd_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input psd_pkg::psd_in_t   in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input psd_pkg::psd_out_t  out_data_o
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // one transaction in flight
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while busy");

  // a result only appears after the block was busy
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a transaction in progress");

  // fields other than status are zero unless a value is delivered
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != psd_pkg::ST_VALUE) |->
      (out_data_o.reg_index == '0) && (out_data_o.row_index == '0) &&
      (out_data_o.reg_value == '0) && (out_data_o.padding == 1'b0))
    else $error("non-value result carries data");

  // delivered values name a real register
  a_reg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == psd_pkg::ST_VALUE) |->
      (out_data_o.reg_index < 4'(psd_pkg::NUM_REGS)))
    else $error("register index out of range");

endmodule

bind psg_register_stream_decompressor psd_chk u_psd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the register stream decompressor, driven with one encoded fragment
module tb;
  import psd_pkg::*;

  typedef enum logic [2:0] {
    P_FRAG, P_ROW, P_KIND, P_RAW, P_OFFSET, P_LENGTH, P_FILL, P_COPY
  } parse_e;

  localparam logic [1:0] HDR_LOW  = 2'd0;
  localparam logic [1:0] HDR_HIGH = 2'd1;
  localparam logic [1:0] HDR_DONE = 2'd2;

  // raw field width per register, register 0 in the low nibble
  localparam logic [55:0] FIELD_W = {4'd8, 4'd8, 4'd8, 4'd5, 4'd5, 4'd5, 4'd8,
                                     4'd5, 4'd4, 4'd8, 4'd4, 4'd8, 4'd4, 4'd8};

  localparam int unsigned IDLE_LIMIT   = 20000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_STEP    = 1400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned NOISE_PCT    = 6;
  localparam int unsigned PLAN_ITEMS   = 440;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  psd_in_t  in_data_i   = '0;
  logic     out_stall_i = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  psd_out_t out_data_o;

  psg_register_stream_decompressor uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // decoder shadow state
  logic [7:0]  dec_buf;
  int unsigned dec_bits;
  logic [1:0]  dec_hdr;
  logic [15:0] dec_total;
  logic [9:0]  dec_frag;
  logic [3:0]  dec_reg;
  int unsigned dec_row;
  parse_e      dec_state;
  logic [7:0]  dec_acc;
  int unsigned dec_need;
  logic [7:0]  dec_src;
  int unsigned dec_rem;
  logic [7:0]  dec_last [NUM_REGS];
  logic [7:0]  dec_hist [NUM_REGS][WIN_ROWS];

  // stimulus construction
  bit          stream_bits [$];
  logic [7:0]  stream_bytes [$];
  int unsigned value_cost [$];
  int unsigned pend_bits = 0;
  psd_in_t     plan [$];
  psd_in_t     pending [$];
  psd_out_t    decoded_due [$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned in_count    = 0;
  int unsigned errors      = 0;
  int unsigned stuck       = 0;
  int unsigned hold_left   = 0;
  int unsigned hold_mark   = 400;
  int unsigned status_seen [5];
  int unsigned padded_seen = 0;
  bit          in_taken    = 1'b0;
  psd_out_t    want;

  function automatic psd_out_t emit_value(input logic [7:0] v);
    psd_out_t    r;
    int unsigned row;
    r = '0;
    row = dec_frag * FRAG_ROWS + dec_row;
    dec_last[dec_reg] = v;
    dec_hist[dec_reg][dec_frag[0] * FRAG_ROWS + dec_row] = v;
    r.status    = ST_VALUE;
    r.reg_index = dec_reg;
    r.row_index = row[ROWABS_W-1:0];
    r.reg_value = v;
    r.padding   = (row >= dec_total);
    if (dec_state == P_COPY) begin
      dec_src = dec_src + 8'd1;
      if (dec_rem > 0) dec_rem--;
      dec_state = (dec_rem == 0) ? P_ROW : P_COPY;
    end else if (dec_state != P_FILL) begin
      dec_state = P_ROW;
    end
    dec_row++;
    if (dec_row >= FRAG_ROWS) begin
      dec_row = 0;
      dec_state = P_FRAG;
      if (dec_reg == NUM_REGS - 1) begin
        dec_reg = '0;
        dec_frag = dec_frag + 10'd1;
      end else begin
        dec_reg = dec_reg + 4'd1;
      end
    end
    return r;
  endfunction

  function automatic psd_out_t predict_decode(input psd_in_t it);
    psd_out_t r;
    logic     b;
    r = '0;
    r.status = ST_TAKEN;
    if (it.mode == MODE_LOAD) begin
      if (dec_hdr == HDR_LOW) begin
        dec_total = {8'd0, it.byte_in};
        dec_hdr = HDR_HIGH;
      end else if (dec_hdr == HDR_HIGH) begin
        dec_total[15:8] = it.byte_in;
        dec_hdr = HDR_DONE;
      end else if (dec_bits == 0) begin
        dec_buf = it.byte_in;
        dec_bits = 8;
      end else begin
        r.status = ST_REFUSED;
      end
      return r;
    end
    if (dec_hdr != HDR_DONE) begin
      r.status = ST_STARVED;
      return r;
    end
    if (dec_frag * FRAG_ROWS >= dec_total) begin
      r.status = ST_FINISHED;
      return r;
    end
    for (int k = 0; k < 12; k++) begin
      if (dec_state == P_FILL) return emit_value(dec_last[dec_reg]);
      if (dec_state == P_COPY) return emit_value(dec_hist[dec_reg][dec_src]);
      if (dec_bits == 0) begin
        r.status = ST_STARVED;
        return r;
      end
      b = dec_buf[7];
      dec_buf = dec_buf << 1;
      dec_bits--;
      case (dec_state)
        P_FRAG: dec_state = b ? P_ROW : P_FILL;
        P_ROW: begin
          if (!b) return emit_value(dec_last[dec_reg]);
          dec_state = P_KIND;
        end
        P_KIND: begin
          dec_acc = '0;
          if (b) begin
            dec_state = P_RAW;
            dec_need = FIELD_W[dec_reg*4 +: 4];
          end else begin
            dec_state = P_OFFSET;
            dec_need = HALF_BITS;
          end
        end
        default: begin
          dec_acc = {dec_acc[6:0], b};
          if (dec_need > 0) dec_need--;
          if (dec_need == 0) begin
            if (dec_state == P_RAW) return emit_value(dec_acc);
            if (dec_state == P_OFFSET) begin
              dec_src = 8'(dec_frag[0] * FRAG_ROWS + dec_row + dec_acc + FRAG_ROWS);
              dec_acc = '0;
              dec_need = HALF_BITS;
              dec_state = P_LENGTH;
            end else begin
              dec_rem = (dec_acc + 1 > FRAG_ROWS - dec_row) ? FRAG_ROWS - dec_row : dec_acc + 1;
              dec_state = P_COPY;
            end
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic psd_in_t make_item(input logic mode, input logic [7:0] data);
    psd_in_t it;
    it.mode = mode;
    it.byte_in = data;
    return it;
  endfunction

  // appends a code of w bits, msb first, followed by run decoded values
  task automatic add_code(input logic [15:0] code, input int unsigned w, input int unsigned run);
    for (int i = w - 1; i >= 0; i--) stream_bits.push_back(code[i]);
    pend_bits += w;
    for (int i = 0; i < run; i++) begin
      value_cost.push_back(pend_bits);
      pend_bits = 0;
    end
  endtask

  task automatic random_code(input int unsigned reg_idx, input int unsigned row,
                             output int unsigned used);
    int unsigned w, sel, v, len;
    logic [6:0]  off;
    w = FIELD_W[reg_idx*4 +: 4];
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      add_code(16'd0, 1, 1);
      used = 1;
    end else if (sel < 75) begin
      case ($urandom_range(0, 7))
        0: v = 0;
        1: v = (1 << w) - 1;
        default: v = $urandom_range(0, (1 << w) - 1);
      endcase
      add_code((16'd3 << w) | v[15:0], w + 2, 1);
      used = 1;
    end else begin
      off = $urandom_range(0, 127);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 15);
      used = (len + 1 < FRAG_ROWS - row) ? len + 1 : FRAG_ROWS - row;
      add_code({2'b10, off, len[6:0]}, 16, used);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t mismatch %s: expected %0h, got %0h", $time, what, exp_v, got_v);
      errors++;
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (pending.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_data_i  <= pending.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_left == 0 && in_count >= hold_mark) begin
      hold_left = HOLD_CYCLES;
      hold_mark = hold_mark + HOLD_STEP;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    in_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (decoded_due.size() == 0) begin
          $display("%0t unexpected result: got %0h", $time, out_data_o);
          errors++;
        end else begin
          want = decoded_due.pop_front();
          check_field("status", want.status, out_data_o.status);
          check_field("reg_index", want.reg_index, out_data_o.reg_index);
          check_field("row_index", want.row_index, out_data_o.row_index);
          check_field("reg_value", want.reg_value, out_data_o.reg_value);
          check_field("padding", want.padding, out_data_o.padding);
          if (want.status <= ST_FINISHED) status_seen[want.status]++;
          if (want.status == ST_VALUE && want.padding) padded_seen++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        in_taken = 1'b1;
        in_count++;
        decoded_due.push_back(predict_decode(in_data_i));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck = 0;
    else stuck++;
    if (stuck >= IDLE_LIMIT) begin
      $display("%0t timeout, %0d results outstanding", $time, decoded_due.size());
      $display("[psg_register_stream_decompressor] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned row, used, need, avail, next_byte, total_rows, third;
    logic [7:0]  b;
    bit          done;

    dec_buf = '0;
    dec_bits = 0;
    dec_hdr = HDR_LOW;
    dec_total = '0;
    dec_frag = '0;
    dec_reg = '0;
    dec_row = 0;
    dec_state = P_FRAG;
    dec_acc = '0;
    dec_need = 0;
    dec_src = '0;
    dec_rem = 0;
    for (int r = 0; r < NUM_REGS; r++) begin
      dec_last[r] = '0;
      for (int s = 0; s < WIN_ROWS; s++) dec_hist[r][s] = '0;
    end
    for (int s = 0; s < 5; s++) status_seen[s] = 0;

    // register 0: every code kind, an unwritten source, a rolling copy, a cut copy
    add_code(16'd1, 1, 0);
    add_code(16'd0, 1, 1);
    add_code((16'd3 << 8) | 16'hFF, 10, 1);
    add_code(16'd3 << 8, 10, 1);
    add_code({2'b10, 7'd0, 7'd0}, 16, 1);
    add_code({2'b10, 7'd127, 7'd3}, 16, 4);
    row = 8;
    while (row < 120) begin
      random_code(0, row, used);
      row += used;
    end
    if (row < FRAG_ROWS) add_code({2'b10, 7'd127, 7'd127}, 16, FRAG_ROWS - row);
    for (int r = 1; r < NUM_REGS; r++) begin
      if (r != 1 && $urandom_range(0, 99) < 60) begin
        add_code(16'd0, 1, FRAG_ROWS);
      end else begin
        add_code(16'd1, 1, 0);
        row = 0;
        while (row < FRAG_ROWS) begin
          random_code(r, row, used);
          row += used;
        end
      end
    end
    while (stream_bits.size() % 8 != 0) stream_bits.push_back($urandom_range(0, 1));
    for (int i = 0; i < stream_bits.size(); i += 8) begin
      for (int j = 0; j < 8; j++) b[7-j] = stream_bits[i+j];
      stream_bytes.push_back(b);
    end

    // header with starved fetches around it; rows past the count get padding
    total_rows = $urandom_range(60, 128);
    plan.push_back(make_item(MODE_FETCH, $urandom_range(0, 255)));
    plan.push_back(make_item(MODE_LOAD, total_rows[7:0]));
    plan.push_back(make_item(MODE_FETCH, $urandom_range(0, 255)));
    plan.push_back(make_item(MODE_LOAD, total_rows[15:8]));
    plan.push_back(make_item(MODE_FETCH, $urandom_range(0, 255)));

    avail = 0;
    next_byte = 0;
    foreach (value_cost[k]) begin
      if (plan.size() >= PLAN_ITEMS) break;
      need = value_cost[k];
      done = 1'b0;
      while (!done) begin
        if ($urandom_range(0, 99) < NOISE_PCT) begin
          if (avail > 0) plan.push_back(make_item(MODE_LOAD, $urandom_range(0, 255)));
          else if (need > 0) plan.push_back(make_item(MODE_FETCH, $urandom_range(0, 255)));
        end
        if (need <= avail) begin
          plan.push_back(make_item(MODE_FETCH, $urandom_range(0, 255)));
          avail -= need;
          done = 1'b1;
        end else if (avail > 0) begin
          plan.push_back(make_item(MODE_FETCH, $urandom_range(0, 255)));
          need -= avail;
          avail = 0;
        end else begin
          plan.push_back(make_item(MODE_LOAD, stream_bytes[next_byte]));
          next_byte++;
          avail = 8;
        end
      end
    end
    // trailing random loads and fetches
    for (int i = 0; i < 6; i++)
      plan.push_back(make_item(i[0] ? MODE_LOAD : MODE_FETCH, $urandom_range(0, 255)));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    third = plan.size() / 3;
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 88 : 0;
      rx_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 23 : 0;
      for (int i = ph * third; i < ((ph == 2) ? plan.size() : (ph + 1) * third); i++)
        pending.push_back(plan[i]);
      while (pending.size() != 0 || in_valid_i) @(posedge clk_i);
    end
    while (decoded_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("header count of %0d rows: %0d values decoded (%0d padded), %0d bytes taken,",
             total_rows, status_seen[ST_VALUE], padded_seen, status_seen[ST_TAKEN]);
    $display("%0d refused, %0d starved and %0d finished fetches, %0d transactions in all",
             status_seen[ST_REFUSED], status_seen[ST_STARVED], status_seen[ST_FINISHED],
             in_count);
    if (errors == 0) begin
      $display("[psg_register_stream_decompressor] OK");
    end else begin
      $display("[psg_register_stream_decompressor] ERROR");
    end
    $finish;
  end

endmodule
